// File: design/sorted_array_set_macros.svh
// ---------------------------------------------------------------------------
// Sorted array set assertion macros
// Shared concurrent assertion forms for the sorted array set checker.
// ---------------------------------------------------------------------------
`ifndef SORTED_ARRAY_SET_MACROS_SVH
`define SORTED_ARRAY_SET_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define SAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SAS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/sas_pkg.sv
// ---------------------------------------------------------------------------
// Sorted array set package
// Operation codes, word types and defaults shared by the sorted array set.
// ---------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned POS_W        = 9;

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [KEY_W-1:0] key;
  } sas_req_t;

  typedef struct packed {
    logic             present;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] count_after;
    logic             full_reject;
  } sas_res_t;

  typedef struct packed {
    logic shift_up;
    logic shift_dn;
  } sas_cmd_t;

  typedef struct packed {
    logic start;
  } sas_srch_ctrl_t;

endpackage

`default_nettype wire

// File: design/sas_cell.sv
// ---------------------------------------------------------------------------
// Sorted array set cell
// Holds one key, compares it with the request and shifts to its neighbors.
// ---------------------------------------------------------------------------
`default_nettype none

module sas_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 9
) (
  input  wire                                 clk_i,
  input  wire logic signed [sas_pkg::KEY_W-1:0] key_req_i,
  input  wire logic signed [sas_pkg::KEY_W-1:0] left_i,
  input  wire logic signed [sas_pkg::KEY_W-1:0] right_i,
  input  wire sas_pkg::sas_cmd_t              cmd_i,
  input  wire logic [IW-1:0]                  lb_i,
  output logic signed [sas_pkg::KEY_W-1:0]    key_o,
  output logic                                lt_o,
  output logic                                eq_o
);
  import sas_pkg::*;

  localparam logic [IW-1:0] IdxL = IW'(IDX);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    lt_q, eq_q;

  always_comb begin
    key_d = key_q;
    if (cmd_i.shift_up) begin
      if (IdxL > lb_i) begin
        key_d = left_i;
      end else if (IdxL == lb_i) begin
        key_d = key_req_i;
      end
    end else if (cmd_i.shift_dn && (IdxL >= lb_i)) begin
      key_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lt_q  <= key_q < key_req_i;
    eq_q  <= key_q == key_req_i;
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

`default_nettype wire

// File: design/sas_lb_search.sv
// ---------------------------------------------------------------------------
// Sorted array set lower-bound search
// Binary search over the cell compare flags, one halving step per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sas_lb_search #(
  parameter int unsigned CAPACITY = sas_pkg::CAPACITY_DEF,
  parameter int unsigned IW       = $clog2(CAPACITY + 1),
  parameter int unsigned AW       = $clog2(CAPACITY)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire sas_pkg::sas_srch_ctrl_t ctrl_i,
  input  wire logic [IW-1:0]           count_i,
  input  wire logic [CAPACITY-1:0]     lt_i,
  output logic                         done_o,
  output logic [IW-1:0]                lb_o
);
  import sas_pkg::*;

  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IW-1:0] mid;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.start) begin
      lo_d = '0;
      hi_d = count_i;
    end else if (lo_q < hi_q) begin
      if (lt_i[mid[AW-1:0]]) begin
        lo_d = mid + IW'(1);
      end else begin
        hi_d = mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign done_o = (lo_q == hi_q);
  assign lb_o   = lo_q;

endmodule

`default_nettype wire

// File: design/sorted_array_set.sv
// An accepted request passes the compare, search and apply states in turn;
// the result strobe and result word are registered from the apply state.
// No new request is taken until the block is idle again; the lower-bound
// search steps once per cycle over the compare flags of the cell row.
// Reset clears the key count, the state and the result strobe; cell contents stay undefined until written.
// The receiver cannot stall; each result is shown for one cycle.
// ---------------------------------------------------------------------------
// Sorted array set
// Ordered set of distinct signed keys held in a row of shifting cells.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_array_set #(
  parameter int unsigned CAPACITY = sas_pkg::CAPACITY_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start_i,
  input  wire sas_pkg::sas_req_t req_i,
  output logic                   busy_o,
  output logic                   valid_o,
  output sas_pkg::sas_res_t      res_o
);
  import sas_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_SRCH  = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [1:0]     op_q;
  logic signed [KEY_W-1:0] key_q;
  logic [IW-1:0]  count_q, count_d;
  logic           valid_q, valid_d;
  sas_res_t       res_q, res_d;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     lt_w, eq_w;
  sas_cmd_t                cmd;
  sas_srch_ctrl_t          srch_ctrl;
  logic                    srch_done;
  logic [IW-1:0]           lb;
  logic                    hit, full;
  logic [IW-1:0]           pos;
  logic                    accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.operation;
      key_q <= req_i.key;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] left_k, right_k;
    if (i == 0) begin : g_first
      assign left_k = key_q;
    end else begin : g_mid_l
      assign left_k = cell_key[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_k = key_q;
    end else begin : g_mid_r
      assign right_k = cell_key[i+1];
    end
    sas_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk_i     (clk_i),
      .key_req_i (key_q),
      .left_i    (left_k),
      .right_i   (right_k),
      .cmd_i     (cmd),
      .lb_i      (lb),
      .key_o     (cell_key[i]),
      .lt_o      (lt_w[i]),
      .eq_o      (eq_w[i])
    );
  end

  assign srch_ctrl.start = (state_q == ST_CMP);

  sas_lb_search #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .AW       (AW)
  ) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (srch_ctrl),
    .count_i (count_q),
    .lt_i    (lt_w),
    .done_o  (srch_done),
    .lb_o    (lb)
  );

  assign hit  = (lb < count_q) && eq_w[lb[AW-1:0]];
  assign full = (count_q == IW'(CAPACITY));

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    cmd      = '0;
    pos      = hit ? lb : count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_SRCH;
      end
      ST_SRCH: begin
        if (srch_done) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d           = ST_IDLE;
        valid_d           = 1'b1;
        res_d.full_reject = 1'b0;
        unique case (op_q)
          OP_INSERT: begin
            pos = lb;
            if (!hit) begin
              if (full) begin
                res_d.full_reject = 1'b1;
              end else begin
                cmd.shift_up = 1'b1;
                count_d      = count_q + IW'(1);
              end
            end
          end
          OP_ERASE: begin
            if (hit) begin
              cmd.shift_dn = 1'b1;
              count_d      = count_q - IW'(1);
            end
          end
          default: begin
          end
        endcase
        res_d.present     = hit;
        res_d.position    = POS_W'(pos);
        res_d.count_after = POS_W'(count_d);
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: design/sas_checker.sv
// ---------------------------------------------------------------------------
// Sorted array set checker
// Port-level assertions on the command handshake and result strobe.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sorted_array_set_macros.svh"

module sas_checker (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    start_i,
  input wire                    busy_o,
  input wire                    valid_o,
  input wire sas_pkg::sas_res_t res_o
);

  `SAS_ASSERT(a_accept_busy, start_i && !busy_o |=> busy_o, "Accepted word did not raise busy.")
  `SAS_ASSERT(a_result_idle, valid_o |-> !busy_o && $past(busy_o), "Result outside a finished item.")
  `SAS_ASSERT(a_single_strobe, valid_o |=> !valid_o, "Result strobe longer than one cycle.")
  `SAS_ASSERT(a_reject_absent, valid_o && res_o.full_reject |-> !res_o.present, "Reject of a held key.")

endmodule

bind sorted_array_set sas_checker u_sas_checker (.*);

`default_nettype wire
